>>> design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared request/result types, hue sector codes, fixed constants and the
// channel weight function for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // request and result payloads
  typedef struct packed {
    logic signed [15:0] hue;
    logic [12:0]        saturation;
    logic [12:0]        brightness;
  } hsv_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_res_t;

  // hue geometry in 1/16 degree units
  localparam int unsigned HueSector = 960;
  localparam int unsigned HueFull   = 5760;
  localparam int unsigned HueBias   = 40320;   // seven full turns, makes hue positive

  // reciprocals for constant division (exact over the ranges used)
  localparam int unsigned HueRecip  = 1457;    // x/45 as (x*1457)>>16, x < 571
  localparam int unsigned SectRecip = 4370;    // x/15 as (x*4370)>>16, x < 90
  localparam int unsigned ByteRecip = 34953;   // x/15 as (x*34953)>>19, x < 3826

  // widths fixed by the field formats
  localparam int unsigned FieldW  = 13;
  localparam int unsigned VsW     = 26;
  localparam int unsigned WeightW = 10;

  // six 60-degree sectors
  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYN  = 3'd2,
    SECT_CYN_BLU  = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // position of the hue inside the color wheel
  typedef struct packed {
    sector_e      sector;
    logic [9:0]   frac;
  } hue_pos_t;

  // weight of a channel's sector component, in 1/960 of chroma
  function automatic logic [WeightW-1:0] chan_weight(input chan_e ch, input hue_pos_t pos);
    logic [WeightW-1:0] full_w;
    logic [WeightW-1:0] ramp_w;
    logic [WeightW-1:0] w;
    full_w = WeightW'(HueSector);
    ramp_w = pos.sector[0] ? WeightW'(full_w - pos.frac) : pos.frac;
    w      = '0;
    case (ch)
      CH_RED: begin
        case (pos.sector)
          SECT_RED_YEL, SECT_MAG_RED: w = full_w;
          SECT_YEL_GRN, SECT_BLU_MAG: w = ramp_w;
          default:                    w = '0;
        endcase
      end
      CH_GREEN: begin
        case (pos.sector)
          SECT_YEL_GRN, SECT_GRN_CYN: w = full_w;
          SECT_RED_YEL, SECT_CYN_BLU: w = ramp_w;
          default:                    w = '0;
        endcase
      end
      CH_BLUE: begin
        case (pos.sector)
          SECT_CYN_BLU, SECT_BLU_MAG: w = full_w;
          SECT_GRN_CYN, SECT_MAG_RED: w = ramp_w;
          default:                    w = '0;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> design/hsv2rgb_sector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Three-stage hue path: wraps the signed hue modulo 5760 and splits it into
// a sector number and the offset inside that sector.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
  input  logic                  clk_i,
  input  logic signed [15:0]    hue_i,
  output hsv2rgb_pkg::hue_pos_t pos_o
);

  logic [16:0]           biased_d, biased_q;
  logic [12:0]           wrap_d, wrap_q;
  hsv2rgb_pkg::hue_pos_t pos_d, pos_q;
  logic signed [17:0]    hue_ext;
  logic [19:0]           turn_prod;
  logic [3:0]            turns;
  logic [18:0]           sect_prod;
  logic [2:0]            sect;

  // stage 1: shift hue into the positive range
  always_comb begin
    hue_ext  = 18'(hue_i);
    biased_d = 17'(hue_ext + 18'(hsv2rgb_pkg::HueBias));
  end

  // stage 2: remove whole turns, 5760 = 128 * 45
  always_comb begin
    turn_prod = 20'(biased_q[16:7]) * 20'(hsv2rgb_pkg::HueRecip);
    turns     = turn_prod[19:16];
    wrap_d    = 13'(biased_q - 17'(17'(turns) * 17'(hsv2rgb_pkg::HueFull)));
  end

  // stage 3: sector and offset, 960 = 64 * 15
  always_comb begin
    sect_prod    = 19'(wrap_q[12:6]) * 19'(hsv2rgb_pkg::SectRecip);
    sect         = sect_prod[18:16];
    pos_d.sector = hsv2rgb_pkg::sector_e'(sect);
    pos_d.frac   = 10'(wrap_q - 13'(13'(sect) * 13'(hsv2rgb_pkg::HueSector)));
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    biased_q <= biased_d;
    wrap_q   <= wrap_d;
    pos_q    <= pos_d;
  end

  assign pos_o = pos_q;

endmodule
`default_nettype wire

>>> design/hsv2rgb_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_channel
// Three-stage channel path: forms the exact channel numerator, clamps it to
// [0,1] and scales it to a truncated byte.
// ----------------------------------------------------------------------------
module hsv2rgb_channel #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned BASE_W    = 26
) (
  input  logic                                   clk_i,
  input  logic signed [BASE_W-1:0]               base_i,
  input  logic [hsv2rgb_pkg::VsW-1:0]            vs_i,
  input  logic [hsv2rgb_pkg::WeightW-1:0]        weight_i,
  output logic [7:0]                             byte_o
);

  localparam int unsigned NumA = BASE_W + 11;
  localparam int unsigned NumB = 2 * FRAC_BITS + 12;
  localparam int unsigned NumW = (NumA > NumB) ? NumA : NumB;
  localparam int unsigned KW   = 2 * FRAC_BITS + 10;
  localparam int unsigned ProdW = hsv2rgb_pkg::VsW + hsv2rgb_pkg::WeightW;
  localparam logic [NumW-1:0] Den = NumW'(hsv2rgb_pkg::HueSector) << (2 * FRAC_BITS);

  logic signed [NumW-1:0] num_d, num_q;
  logic [17:0]            scaled_d, scaled_q;
  logic [7:0]             byte_d, byte_q;
  logic signed [NumW-1:0] base_ext;
  logic [ProdW-1:0]       vw;
  logic [KW-1:0]          clamped;
  logic [KW+7:0]          times255;
  logic [27:0]            div_prod;

  // stage 4: numerator = 960 * base + vs * weight
  always_comb begin
    base_ext = NumW'(base_i);
    vw       = ProdW'(vs_i) * ProdW'(weight_i);
    num_d    = (base_ext <<< 10) - (base_ext <<< 6) + $signed(NumW'(vw));
  end

  // stage 5: clamp, times 255, drop the 2^(2F) part of the denominator
  always_comb begin
    if (num_q[NumW-1]) begin
      clamped = '0;
    end else if (num_q > $signed(Den)) begin
      clamped = Den[KW-1:0];
    end else begin
      clamped = num_q[KW-1:0];
    end
    times255 = {clamped, 8'b0} - {8'b0, clamped};
    scaled_d = times255[2*FRAC_BITS+17:2*FRAC_BITS];
  end

  // stage 6: divide by the remaining 960 = 64 * 15
  always_comb begin
    div_prod = 28'(scaled_q[17:6]) * 28'(hsv2rgb_pkg::ByteRecip);
    byte_d   = div_prod[26:19];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    scaled_q <= scaled_d;
    byte_q   <= byte_d;
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

>>> design/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-stage pipeline converting one HSV color per clock to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   A request (hue, saturation, brightness) is taken at a rising edge with
//   start high and busy low. busy is always low, so a new request may be
//   issued in every cycle.
//   Each request gives one result on res_o, shown for exactly one cycle with
//   res_valid_o high, in request order.
//   Throughput is one request per clock; the stages are hue bias, hue wrap,
//   sector split (chroma and offset formed alongside), channel numerator,
//   clamp and scale, and the final divide by 960 into the output register.
//   Reset clears the valid bits only; no result appears until a request has
//   passed through the pipeline. The receiver cannot stall, so the pipeline
//   never holds and every result leaves on its fixed cycle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  hsv2rgb_pkg::hsv_req_t req_i,
  output logic                  res_valid_o,
  output hsv2rgb_pkg::rgb_res_t res_o
);

  localparam int unsigned FieldW = hsv2rgb_pkg::FieldW;
  localparam int unsigned VsW    = hsv2rgb_pkg::VsW;
  localparam int unsigned OneW   = FieldW + FRAC_BITS;
  localparam int unsigned BaseW  = ((OneW > VsW) ? OneW : VsW) + 1;
  localparam int unsigned Depth  = 6;

  logic [Depth-1:0]          valid_d, valid_q;
  logic [VsW-1:0]            vs1_d, vs1_q, vs2_q, vs3_q;
  logic [FieldW-1:0]         val1_q;
  logic signed [BaseW-1:0]   base2_d, base2_q, base3_q;
  hsv2rgb_pkg::hue_pos_t     pos;
  logic [7:0]                red, green, blue;

  // no backpressure: always ready
  assign busy = 1'b0;

  // valid bits travel alongside the data
  assign valid_d = {valid_q[Depth-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hue path, stages 1 to 3
  hsv2rgb_sector u_sector (
    .clk_i (clk_i),
    .hue_i (req_i.hue),
    .pos_o (pos)
  );

  // chroma and offset: base = V*one - V*S
  assign vs1_d   = VsW'(req_i.brightness) * VsW'(req_i.saturation);
  assign base2_d = $signed(BaseW'({val1_q, FRAC_BITS'(0)})) - $signed(BaseW'(vs1_q));

  always_ff @(posedge clk_i) begin
    vs1_q   <= vs1_d;
    val1_q  <= req_i.brightness;
    vs2_q   <= vs1_q;
    base2_q <= base2_d;
    vs3_q   <= vs2_q;
    base3_q <= base2_q;
  end

  // channel paths, stages 4 to 6
  hsv2rgb_channel #(.FRAC_BITS(FRAC_BITS), .BASE_W(BaseW)) u_red (
    .clk_i    (clk_i),
    .base_i   (base3_q),
    .vs_i     (vs3_q),
    .weight_i (hsv2rgb_pkg::chan_weight(hsv2rgb_pkg::CH_RED, pos)),
    .byte_o   (red)
  );

  hsv2rgb_channel #(.FRAC_BITS(FRAC_BITS), .BASE_W(BaseW)) u_green (
    .clk_i    (clk_i),
    .base_i   (base3_q),
    .vs_i     (vs3_q),
    .weight_i (hsv2rgb_pkg::chan_weight(hsv2rgb_pkg::CH_GREEN, pos)),
    .byte_o   (green)
  );

  hsv2rgb_channel #(.FRAC_BITS(FRAC_BITS), .BASE_W(BaseW)) u_blue (
    .clk_i    (clk_i),
    .base_i   (base3_q),
    .vs_i     (vs3_q),
    .weight_i (hsv2rgb_pkg::chan_weight(hsv2rgb_pkg::CH_BLUE, pos)),
    .byte_o   (blue)
  );

  // result
  assign res_valid_o = valid_q[Depth-1];
  assign res_o.red   = red;
  assign res_o.green = green;
  assign res_o.blue  = blue;

endmodule
`default_nettype wire
